/* rtl/gmprc_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// gmprc_pkg
// Shared constants, types and helpers for the grid route check block.
// ---------------------------------------------------------------------------
package gmprc_pkg;

   localparam int MAX_COLS   = 64;
   localparam int MAX_ROWS   = 64;
   localparam int VALUE_BITS = 10;
   localparam int COST_BITS  = 17;

   localparam int COL_BITS   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_BITS   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   // configuration port
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 7;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ROW_COUNT = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_COL_COUNT = CSR_IDX_BITS'(1);

   // counts held one bit wider than the indexes so the maximum fits
   localparam int CNT_BITS = COL_BITS > ROW_BITS ? COL_BITS + 1 : ROW_BITS + 1;

   localparam logic [COST_BITS-1:0] SAT_MAX = '1;

   // position of one cell in the grid, decided when it is accepted
   typedef struct packed {
      logic [COL_BITS-1:0] col;
      logic [ROW_BITS-1:0] row;
      logic                row_end;
      logic                grid_last;
   } pos_type;

   // one entry of the row buffer
   typedef struct packed {
      logic                 reach;
      logic [COST_BITS-1:0] cost;
   } cost_word_type;

   localparam int WORD_BITS = $bits(cost_word_type);

   function automatic logic [COST_BITS-1:0] sat_add(
      input logic [COST_BITS-1:0] a,
      input logic [COST_BITS-1:0] b
   );
      logic [COST_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COST_BITS] ? SAT_MAX : s[COST_BITS-1:0];
   endfunction

   function automatic logic [CNT_BITS-1:0] clamp_count(
      input logic [CSR_DATA_BITS-1:0] v,
      input logic [CNT_BITS-1:0]      hi
   );
      logic [CNT_BITS+CSR_DATA_BITS-1:0] vw;
      logic [CNT_BITS+CSR_DATA_BITS-1:0] hw;
      vw = (CNT_BITS+CSR_DATA_BITS)'(v);
      hw = (CNT_BITS+CSR_DATA_BITS)'(hi);
      if (vw == '0) begin
         return CNT_BITS'(1);
      end else if (vw > hw) begin
         return hi;
      end
      return vw[CNT_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

/* rtl/grid_min_path_route_check_top.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// grid_min_path_route_check_top
// Minimum right/down path sum over a streamed grid with blocked cells,
// checked against a danger limit of largest cell plus largest row sum.
// ---------------------------------------------------------------------------
//   channel  | direction | ports                       | handshake
//   req_     | in        | cell_value, blocked         | valid / stall
//   rsp_     | out       | route_ok, reachable, cost.. | valid / stall
//   csr_     | in        | we, index, wdata            | write on we
//
// one cell per cycle sustained while no last cell waits on a held result;
// a grid's last cell passes the cell register, then the result register
// the row buffer is read for each cell as it is accepted and written as the
// cell leaves the cell register, with a bypass when both hit the same column
// reset is synchronous and leaves a 1 x 1 grid; the row buffer is not cleared
// cells keep flowing while a result waits; only a last cell waits for it
// ---------------------------------------------------------------------------
module grid_min_path_route_check_top
   import gmprc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire logic [VALUE_BITS-1:0]    req_cell_value,
   input  wire logic                     req_blocked,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      logic                     rsp_route_ok,
   output      logic                     rsp_reachable,
   output      logic [COST_BITS-1:0]     rsp_path_cost,
   output      logic [COST_BITS-1:0]     rsp_danger_limit,
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   logic                 accept;
   logic                 restart;
   logic                 busy;
   pos_type              cur_pos;
   logic                 ram_wr_en;
   logic [COL_BITS-1:0]  ram_wr_addr;
   logic [WORD_BITS-1:0] ram_wr_data;
   logic [WORD_BITS-1:0] ram_rd_data;

   assign req_stall = busy;
   assign accept    = req_valid && !req_stall;

   gmprc_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .cur_pos   (cur_pos),
      .restart   (restart)
   );

   gmprc_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAX_COLS)
   ) u_row_buf (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (cur_pos.col),
      .rd_data (ram_rd_data)
   );

   gmprc_path u_path (
      .clock            (clock),
      .reset            (reset),
      .restart          (restart),
      .accept           (accept),
      .cur_pos          (cur_pos),
      .cell_value       (req_cell_value),
      .blocked          (req_blocked),
      .ram_rd_data      (ram_rd_data),
      .ram_wr_en        (ram_wr_en),
      .ram_wr_addr      (ram_wr_addr),
      .ram_wr_data      (ram_wr_data),
      .busy             (busy),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_route_ok     (rsp_route_ok),
      .rsp_reachable    (rsp_reachable),
      .rsp_path_cost    (rsp_path_cost),
      .rsp_danger_limit (rsp_danger_limit)
   );

endmodule
`default_nettype wire

/* rtl/gmprc_ram.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// gmprc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module gmprc_ram #(
   parameter  int WIDTH     = 8,
   parameter  int DEPTH     = 64,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [ADDR_BITS-1:0]     wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [ADDR_BITS-1:0]     rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

/* rtl/gmprc_seq.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// gmprc_seq
// Grid size registers and the row/column counters on the accept side.
// ---------------------------------------------------------------------------
module gmprc_seq
   import gmprc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  wire logic                     accept,
   output      pos_type                  cur_pos,
   output      logic                     restart
);

   logic [CNT_BITS-1:0] row_count_ff, row_count_in;
   logic [CNT_BITS-1:0] col_count_ff, col_count_in;
   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [CNT_BITS-1:0] col_plus;
   logic [CNT_BITS-1:0] row_plus;

   assign col_plus = CNT_BITS'(col_ff) + CNT_BITS'(1);
   assign row_plus = CNT_BITS'(row_ff) + CNT_BITS'(1);

   assign cur_pos.col       = col_ff;
   assign cur_pos.row       = row_ff;
   assign cur_pos.row_end   = col_plus >= col_count_ff;
   assign cur_pos.grid_last = cur_pos.row_end && (row_plus >= row_count_ff);

   assign restart = csr_we && (csr_index == CSR_ROW_COUNT || csr_index == CSR_COL_COUNT);

   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      if (restart) begin
         if (csr_index == CSR_ROW_COUNT) begin
            row_count_in = clamp_count(csr_wdata, CNT_BITS'(MAX_ROWS));
         end else begin
            col_count_in = clamp_count(csr_wdata, CNT_BITS'(MAX_COLS));
         end
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (cur_pos.row_end) begin
            col_in = '0;
            row_in = cur_pos.grid_last ? '0 : row_plus[ROW_BITS-1:0];
         end else begin
            col_in = col_plus[COL_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= CNT_BITS'(1);
         col_count_ff <= CNT_BITS'(1);
         col_ff       <= '0;
         row_ff       <= '0;
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/gmprc_path.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// gmprc_path
// Cell register, path cost / danger limit datapath and result register.
// ---------------------------------------------------------------------------
module gmprc_path
   import gmprc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  restart,
   input  wire logic                  accept,
   input  wire pos_type               cur_pos,
   input  wire logic [VALUE_BITS-1:0] cell_value,
   input  wire logic                  blocked,
   input  wire logic [WORD_BITS-1:0]  ram_rd_data,
   output      logic                  ram_wr_en,
   output      logic [COL_BITS-1:0]   ram_wr_addr,
   output      logic [WORD_BITS-1:0]  ram_wr_data,
   output      logic                  busy,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      logic                  rsp_route_ok,
   output      logic                  rsp_reachable,
   output      logic [COST_BITS-1:0]  rsp_path_cost,
   output      logic [COST_BITS-1:0]  rsp_danger_limit
);

   // cell register
   logic                  in_valid_ff, in_valid_in;
   logic [VALUE_BITS-1:0] in_value_ff;
   logic                  in_blocked_ff;
   pos_type               in_pos_ff;
   logic                  byp_hit_ff;
   cost_word_type         byp_data_ff;

   // scan state
   logic [COST_BITS-1:0]  left_cost_ff;
   logic                  left_reach_ff;
   logic [COST_BITS-1:0]  row_sum_ff;
   logic [COST_BITS-1:0]  max_row_ff;
   logic [VALUE_BITS-1:0] max_cell_ff;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_route_ok_ff;
   logic                  rsp_reachable_ff;
   logic [COST_BITS-1:0]  rsp_path_cost_ff;
   logic [COST_BITS-1:0]  rsp_danger_limit_ff;

   logic                  fire;
   cost_word_type         up_word;
   cost_word_type         new_word;
   logic [COST_BITS-1:0]  v;
   logic                  up_ok, lf_ok, corner;
   logic [COST_BITS-1:0]  best;
   logic [COST_BITS-1:0]  row_sum_base;
   logic [COST_BITS-1:0]  row_sum_new;
   logic [VALUE_BITS-1:0] max_cell_new;
   logic [COST_BITS-1:0]  max_row_new;
   logic [COST_BITS-1:0]  limit;

   assign fire = in_valid_ff && !(in_pos_ff.grid_last && rsp_valid_ff && rsp_stall);
   assign busy = in_valid_ff && !fire;

   // row above comes from the buffer, or from the write that raced the read
   assign up_word = byp_hit_ff ? byp_data_ff : cost_word_type'(ram_rd_data);

   assign v      = in_blocked_ff ? '0 : COST_BITS'(in_value_ff);
   assign corner = (in_pos_ff.row == '0) && (in_pos_ff.col == '0);
   assign up_ok  = (in_pos_ff.row != '0) && up_word.reach;
   assign lf_ok  = (in_pos_ff.col != '0) && left_reach_ff;

   always_comb begin
      if (up_ok && !(lf_ok && left_cost_ff < up_word.cost)) begin
         best = up_word.cost;
      end else begin
         best = left_cost_ff;
      end
      new_word.reach = !in_blocked_ff && (corner || up_ok || lf_ok);
      if (!new_word.reach) begin
         new_word.cost = '0;
      end else if (corner) begin
         new_word.cost = v;
      end else begin
         new_word.cost = sat_add(best, v);
      end
   end

   assign row_sum_base = (in_pos_ff.col == '0) ? '0 : row_sum_ff;
   assign row_sum_new  = sat_add(row_sum_base, v);
   assign max_cell_new = (v[VALUE_BITS-1:0] > max_cell_ff) ? v[VALUE_BITS-1:0] : max_cell_ff;
   assign max_row_new  = (in_pos_ff.row_end && row_sum_new > max_row_ff) ? row_sum_new
                                                                         : max_row_ff;
   assign limit        = sat_add(COST_BITS'(max_cell_new), max_row_new);

   assign ram_wr_en   = fire;
   assign ram_wr_addr = in_pos_ff.col;
   assign ram_wr_data = new_word;

   always_comb begin
      priority if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      priority if (fire && in_pos_ff.grid_last) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         left_reach_ff <= 1'b0;
         left_cost_ff  <= '0;
         row_sum_ff    <= '0;
         max_row_ff    <= '0;
         max_cell_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (restart) begin
            left_reach_ff <= 1'b0;
            left_cost_ff  <= '0;
            row_sum_ff    <= '0;
            max_row_ff    <= '0;
            max_cell_ff   <= '0;
         end else if (fire) begin
            left_reach_ff <= new_word.reach;
            left_cost_ff  <= new_word.cost;
            row_sum_ff    <= row_sum_new;
            if (in_pos_ff.grid_last) begin
               max_row_ff  <= '0;
               max_cell_ff <= '0;
            end else begin
               max_row_ff  <= max_row_new;
               max_cell_ff <= max_cell_new;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_value_ff   <= cell_value;
         in_blocked_ff <= blocked;
         in_pos_ff     <= cur_pos;
         byp_hit_ff    <= fire && (in_pos_ff.col == cur_pos.col);
         byp_data_ff   <= new_word;
      end
      if (fire && in_pos_ff.grid_last) begin
         rsp_route_ok_ff     <= new_word.reach && (new_word.cost <= limit);
         rsp_reachable_ff    <= new_word.reach;
         rsp_path_cost_ff    <= new_word.cost;
         rsp_danger_limit_ff <= limit;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_route_ok     = rsp_route_ok_ff;
   assign rsp_reachable    = rsp_reachable_ff;
   assign rsp_path_cost    = rsp_path_cost_ff;
   assign rsp_danger_limit = rsp_danger_limit_ff;

   a_no_accept_when_held: assert property (@(posedge clock) disable iff (reset)
      busy |-> !accept)
      else $error("cell accepted while the held cell could not move on");

   a_last_cell_gives_item: assert property (@(posedge clock) disable iff (reset)
      fire && in_pos_ff.grid_last |=> rsp_valid_ff)
      else $error("last cell of the grid produced no item");

   a_unreached_cost_zero: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en && !new_word.reach |-> new_word.cost == '0)
      else $error("unreachable cell written with a non-zero cost");

   a_route_ok_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_route_ok_ff |->
         rsp_reachable_ff && (rsp_path_cost_ff <= rsp_danger_limit_ff))
      else $error("route passed without reach or within limit");

endmodule
`default_nettype wire
